### src/cal_pkg.sv
// Shared types and codes for the cursor array list.
// Holds the word structs, operation and status codes, and the cell command type.
`default_nettype none

package cal_pkg;

  // Operation codes carried in the func field
  localparam logic [3:0] FN_INS_BEFORE = 4'd0;
  localparam logic [3:0] FN_INS_AFTER  = 4'd1;
  localparam logic [3:0] FN_DELETE     = 4'd2;
  localparam logic [3:0] FN_NEXT       = 4'd3;
  localparam logic [3:0] FN_PREV       = 4'd4;
  localparam logic [3:0] FN_START      = 4'd5;
  localparam logic [3:0] FN_END        = 4'd6;
  localparam logic [3:0] FN_READ       = 4'd7;
  localparam logic [3:0] FN_WRITE      = 4'd8;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // Command broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD,   // keep contents
    CELL_OPEN,   // cells above the slot take the lower neighbor, the slot loads
    CELL_CLOSE,  // cells at and above the slot take the upper neighbor
    CELL_LOAD    // the slot loads, all others hold
  } cell_cmd_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic [5:0]         index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               moved;
    logic signed [31:0] read_value;
    logic signed [31:0] current_value;
    logic [6:0]         item_count;
    logic [5:0]         cursor_pos;
  } out_word_t;

endpackage

`default_nettype wire

### src/cal_cell.sv
// One storage cell of the list row: holds one element and trades it with its neighbors.
// Depends on cal_pkg for the cell command type.
`default_nettype none

module cal_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 6,
  parameter int IDX        = 0
) (
  input  wire                    clk,
  input  cal_pkg::cell_cmd_t     cmd,
  input  wire [PW-1:0]           at,
  input  wire [DATA_WIDTH-1:0]   wdata,
  input  wire [DATA_WIDTH-1:0]   lower,
  input  wire [DATA_WIDTH-1:0]   upper,
  input  wire [PW-1:0]           rd_sel,
  input  wire [PW-1:0]           cur_sel,
  output logic [DATA_WIDTH-1:0]  data,
  output logic [DATA_WIDTH-1:0]  rd_tap,
  output logic [DATA_WIDTH-1:0]  cur_tap
);
  import cal_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at_slot;
  logic                  above_slot;

  assign at_slot    = (MY_IDX == at);
  assign above_slot = (MY_IDX > at);

  // Pick the next contents from the broadcast command
  always_comb begin
    data_nxt = data_r;
    unique case (cmd)
      CELL_HOLD:  data_nxt = data_r;
      CELL_OPEN: begin
        if (at_slot) data_nxt = wdata;
        else if (above_slot) data_nxt = lower;
      end
      CELL_CLOSE: begin
        if (at_slot || above_slot) data_nxt = upper;
      end
      CELL_LOAD: begin
        if (at_slot) data_nxt = wdata;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Drive the element onto the read buses only when selected
  assign data    = data_r;
  assign rd_tap  = (MY_IDX == rd_sel)  ? data_r : '0;
  assign cur_tap = (MY_IDX == cur_sel) ? data_r : '0;

endmodule

`default_nettype wire

### src/cursor_array_list.sv
// Top level of the cursor array list: command decode, cursor and length, cell row, result word.
// Depends on cal_pkg and cal_cell.
//
//   channel | ports                      | moves
//   --------+----------------------------+------------------------------
//   input   | in_valid, in_ready, in_data | one operation word
//   output  | out_valid, out_ready, out_data | one result word per operation
//
// A word is taken each cycle while the result path keeps up; the cell row updates at the
// accepting edge, then the selected elements are registered into the output register once
// that register is free to take the result word.
// On insert or delete the cells above the slot, and on delete the slot too, shift together.
// in_ready drops only while a gathered result waits on a full output register.
// Synchronous active-low reset empties the list; element contents are not cleared.
`default_nettype none

module cursor_array_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cal_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cal_pkg::out_word_t  out_data
);
  import cal_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = (LW > 6) ? LW : 6;
  localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

  // Control state
  logic [LW-1:0] len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          busy_r, busy_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          moved_r, moved_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [PW-1:0] rd_sel_r, rd_sel_nxt;
  logic          out_valid_r;
  out_word_t     out_data_r;

  // Cell row broadcast
  cell_cmd_t             cmd;
  cell_cmd_t             op_cmd;
  logic [PW-1:0]         op_at;
  logic [DATA_WIDTH-1:0] wdata;

  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_taps  [CAPACITY];
  logic [DATA_WIDTH-1:0] cur_taps [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_bus;
  logic [DATA_WIDTH-1:0] cur_bus;

  logic accept;
  logic out_free;
  logic idx_bad;
  logic [PW-1:0] idx_pos;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !busy_r || out_free;
  assign accept   = in_valid && in_ready;
  assign wdata    = DATA_WIDTH'($unsigned(in_data.value));
  assign idx_bad  = (CW'(in_data.index) >= CW'(len_r));
  assign idx_pos  = PW'(in_data.index);

  // Decode the operation against the current length and cursor
  always_comb begin
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    stat_nxt  = STAT_OK;
    moved_nxt = 1'b0;
    rd_ok_nxt = 1'b0;
    rd_sel_nxt = idx_pos;
    op_cmd    = CELL_HOLD;
    op_at     = pos_r;
    unique case (in_data.func)
      FN_INS_BEFORE, FN_INS_AFTER: begin
        if (len_r == CAP_LEN) begin
          stat_nxt = STAT_FULL;
        end else if (len_r == '0) begin
          op_cmd  = CELL_LOAD;
          op_at   = '0;
          pos_nxt = '0;
          len_nxt = LW'(1);
        end else if (in_data.func == FN_INS_BEFORE) begin
          op_cmd  = CELL_OPEN;
          op_at   = pos_r;
          pos_nxt = pos_r + PW'(1);
          len_nxt = len_r + LW'(1);
        end else begin
          op_cmd  = CELL_OPEN;
          op_at   = pos_r + PW'(1);
          len_nxt = len_r + LW'(1);
        end
      end
      FN_DELETE: begin
        if (len_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else if (len_r == LW'(1)) begin
          len_nxt = '0;
          pos_nxt = '0;
        end else if (LW'(pos_r) == len_r - LW'(1)) begin
          pos_nxt = PW'(len_r - LW'(2));
          len_nxt = len_r - LW'(1);
        end else begin
          op_cmd  = CELL_CLOSE;
          op_at   = pos_r;
          len_nxt = len_r - LW'(1);
        end
      end
      FN_NEXT: begin
        if (len_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else if (LW'(pos_r) + LW'(1) < len_r) begin
          pos_nxt   = pos_r + PW'(1);
          moved_nxt = 1'b1;
        end
      end
      FN_PREV: begin
        if (len_r == '0) begin
          stat_nxt = STAT_EMPTY;
        end else if (pos_r != '0) begin
          pos_nxt   = pos_r - PW'(1);
          moved_nxt = 1'b1;
        end
      end
      FN_START: begin
        if (len_r == '0) stat_nxt = STAT_EMPTY;
        else pos_nxt = '0;
      end
      FN_END: begin
        if (len_r == '0) stat_nxt = STAT_EMPTY;
        else pos_nxt = PW'(len_r - LW'(1));
      end
      FN_READ: begin
        if (idx_bad) stat_nxt = STAT_RANGE;
        else rd_ok_nxt = 1'b1;
      end
      FN_WRITE: begin
        if (idx_bad) begin
          stat_nxt = STAT_RANGE;
        end else begin
          op_cmd = CELL_LOAD;
          op_at  = idx_pos;
        end
      end
      default: stat_nxt = STAT_OK;
    endcase
  end

  // Drive the cells only on an accepted word
  assign cmd = accept ? op_cmd : CELL_HOLD;

  // Row of cells, each linked to its lower and upper neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_q;
    logic [DATA_WIDTH-1:0] upper_q;
    if (i == 0) begin : g_lo_end
      assign lower_q = cell_q[i];
    end else begin : g_lo
      assign lower_q = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_end
      assign upper_q = cell_q[i];
    end else begin : g_hi
      assign upper_q = cell_q[i+1];
    end
    cal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .at      (op_at),
      .wdata   (wdata),
      .lower   (lower_q),
      .upper   (upper_q),
      .rd_sel  (rd_sel_r),
      .cur_sel (pos_r),
      .data    (cell_q[i]),
      .rd_tap  (rd_taps[i]),
      .cur_tap (cur_taps[i])
    );
  end

  // Collect the selected elements from the row
  always_comb begin
    rd_bus  = '0;
    cur_bus = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_bus  = rd_bus | rd_taps[k];
      cur_bus = cur_bus | cur_taps[k];
    end
  end

  // Hold a gathered result until the output register frees up
  always_comb begin
    busy_nxt = busy_r;
    if (accept) busy_nxt = 1'b1;
    else if (out_free) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      pos_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (accept) begin
        len_r <= len_nxt;
        pos_r <= pos_nxt;
      end
      if (busy_r && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Per-word side information for the gather cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      stat_r   <= stat_nxt;
      moved_r  <= moved_nxt;
      rd_ok_r  <= rd_ok_nxt;
      rd_sel_r <= rd_sel_nxt;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (busy_r && out_free) begin
      out_data_r.status        <= stat_r;
      out_data_r.moved         <= moved_r;
      out_data_r.read_value    <= rd_ok_r ? 32'(rd_bus) : '0;
      out_data_r.current_value <= (len_r != '0) ? 32'(cur_bus) : '0;
      out_data_r.item_count    <= 7'(len_r);
      out_data_r.cursor_pos    <= 6'(pos_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n) len_r <= CAP_LEN)
    else $error("list length above capacity");
  a_pos_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> (pos_r == '0))
    else $error("cursor off zero on empty list");
  a_pos_in: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (LW'(pos_r) < len_r))
    else $error("cursor beyond list end");
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STAT_FULL) |-> (out_data_r.item_count == 7'(CAPACITY)))
    else $error("full status without full count");

endmodule

`default_nettype wire

### tb/cal_result_checker.sv
// Result checker for the cursor array list: mirrors the list, predicts each result word
// and compares it with what the block returns. Depends on cal_pkg.
module cal_result_checker (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  cal_pkg::in_word_t  in_data,
  input  wire                out_valid,
  input  wire                out_ready,
  input  cal_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 list_len
);
  import cal_pkg::*;

  localparam int SLOTS = 64;

  // Mirror of the list: element store, element count and cursor
  logic [31:0] slot_val [0:SLOTS-1];
  int          count_m;
  int          cursor_m;

  out_word_t   due_results [$];
  int          fails;

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
    fails      = 0;
    count_m    = 0;
    cursor_m   = 0;
  end

  // Apply one operation to the mirror and build the result word it yields
  task automatic predict_list_op(input in_word_t w, output out_word_t r);
    int i;
    r = '0;
    case (w.func)
      FN_INS_BEFORE, FN_INS_AFTER: begin
        if (count_m >= SLOTS) begin
          r.status = STAT_FULL;
        end else if (count_m == 0) begin
          slot_val[0] = w.value;
          cursor_m = 0;
          count_m = 1;
        end else if (w.func == FN_INS_BEFORE) begin
          for (i = count_m; i > cursor_m; i--) slot_val[i] = slot_val[i-1];
          slot_val[cursor_m] = w.value;
          cursor_m++;
          count_m++;
        end else begin
          for (i = count_m; i > cursor_m + 1; i--) slot_val[i] = slot_val[i-1];
          slot_val[cursor_m+1] = w.value;
          count_m++;
        end
      end
      FN_DELETE: begin
        if (count_m == 0) begin
          r.status = STAT_EMPTY;
        end else if (count_m == 1) begin
          count_m = 0;
          cursor_m = 0;
        end else if (cursor_m == count_m - 1) begin
          cursor_m = count_m - 2;
          count_m--;
        end else begin
          for (i = cursor_m + 1; i < count_m; i++) slot_val[i-1] = slot_val[i];
          count_m--;
        end
      end
      FN_NEXT: begin
        if (count_m == 0) r.status = STAT_EMPTY;
        else if (cursor_m + 1 < count_m) begin
          cursor_m++;
          r.moved = 1'b1;
        end
      end
      FN_PREV: begin
        if (count_m == 0) r.status = STAT_EMPTY;
        else if (cursor_m > 0) begin
          cursor_m--;
          r.moved = 1'b1;
        end
      end
      FN_START: begin
        if (count_m == 0) r.status = STAT_EMPTY;
        else cursor_m = 0;
      end
      FN_END: begin
        if (count_m == 0) r.status = STAT_EMPTY;
        else cursor_m = count_m - 1;
      end
      FN_READ: begin
        if (int'(w.index) >= count_m) r.status = STAT_RANGE;
        else r.read_value = slot_val[w.index];
      end
      FN_WRITE: begin
        if (int'(w.index) >= count_m) r.status = STAT_RANGE;
        else slot_val[w.index] = w.value;
      end
      default: ;
    endcase
    if (count_m > 0) r.current_value = slot_val[cursor_m];
    r.item_count = 7'(count_m);
    r.cursor_pos = 6'(cursor_m);
  endtask

  // Watch both channels; compare returned words, then queue the prediction for a new one
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      due_results.delete();
      count_m = 0;
      cursor_m = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected result word: st=%0d mv=%0d rd=%h cur=%h n=%0d pos=%0d",
                     got.status, got.moved, got.read_value, got.current_value,
                     got.item_count, got.cursor_pos);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.moved !== want.moved ||
              got.read_value !== want.read_value ||
              got.current_value !== want.current_value ||
              got.item_count !== want.item_count || got.cursor_pos !== want.cursor_pos) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch: exp st=%0d mv=%0d rd=%h cur=%h n=%0d pos=%0d",
                       want.status, want.moved, want.read_value, want.current_value,
                       want.item_count, want.cursor_pos);
              $display("          got st=%0d mv=%0d rd=%h cur=%h n=%0d pos=%0d",
                       got.status, got.moved, got.read_value, got.current_value,
                       got.item_count, got.cursor_pos);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_list_op(in_data, want);
        due_results.push_back(want);
      end
    end
    // Publish counters after the edge so readers see settled values
    fail_count <= fails;
    pending    <= due_results.size();
    list_len   <= count_m;
  end

endmodule

### tb/tb_cursor_array_list.sv
// Testbench top for the cursor array list: clock, reset, operation stimulus with random
// idling on both channels, watchdog and verdict. Depends on cal_pkg and cal_result_checker.
module tb_cursor_array_list;
  import cal_pkg::*;

  localparam int         RAND_ITEMS = 400;
  localparam int         CALM_ITEMS = 60;
  localparam int         STALL_LIMIT = 400;
  localparam logic [3:0] FN_NOISE_LO = FN_WRITE + 4'd1;
  localparam logic [3:0] FN_NOISE_HI = 4'hF;

  typedef enum int { MIX_GROW, MIX_SHRINK, MIX_WANDER } op_mix_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      calm = 1'b0;

  int fail_count;
  int pending;
  int list_len;
  int idle_run = 0;

  always #5 clk = ~clk;

  cursor_array_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cal_result_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .list_len  (list_len)
  );

  // Stall the result side in bursts; the stall rate is drawn anew every window
  int hold_cnt = 0;
  int stall_pct = 0;
  int win_cnt = 0;
  always @(posedge clk) begin
    if (win_cnt == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 8;
        default: stall_pct <= 25;
      endcase
      win_cnt <= 40;
    end else begin
      win_cnt <= win_cnt - 1;
    end
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      hold_cnt <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  function automatic in_word_t op_word(logic [3:0] f, logic [31:0] v, logic [5:0] idx);
    in_word_t w;
    w.func = f;
    w.value = v;
    w.index = idx;
    return w;
  endfunction

  // Build a random word, leaning toward the segment's mix and toward live indexes
  function automatic in_word_t rand_word(op_mix_t mix, int len_now);
    in_word_t w;
    int p;
    int q;
    p = $urandom_range(0, 99);
    if (p < 3) w.func = 4'($urandom_range(FN_NOISE_LO, FN_NOISE_HI));
    else if (mix == MIX_GROW && p < 65) w.func = $urandom_range(0, 1) ? FN_INS_BEFORE : FN_INS_AFTER;
    else if (mix == MIX_SHRINK && p < 55) w.func = FN_DELETE;
    else w.func = 4'($urandom_range(FN_INS_BEFORE, FN_WRITE));
    q = $urandom_range(0, 99);
    if (q < 5) w.value = 32'h8000_0000;
    else if (q < 10) w.value = 32'h7FFF_FFFF;
    else w.value = $urandom();
    q = $urandom_range(0, 99);
    if (q < 50 && len_now > 0) w.index = 6'($urandom_range(0, len_now - 1));
    else if (q < 60) w.index = 6'((len_now > 63) ? 63 : len_now);
    else w.index = 6'($urandom_range(0, 63));
    return w;
  endfunction

  // Present a word and hold it until accepted; returns at the accepting edge
  task automatic push_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int total;
    int seg_len;
    int gap_pct;
    int k;
    op_mix_t mix;
    in_word_t w;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-list corners and ignored codes
    push_word(op_word(FN_DELETE, 32'h0, 6'd0));
    push_word(op_word(FN_NEXT, 32'h0, 6'd0));
    push_word(op_word(FN_PREV, 32'h0, 6'd0));
    push_word(op_word(FN_START, 32'h0, 6'd0));
    push_word(op_word(FN_END, 32'h0, 6'd0));
    push_word(op_word(FN_READ, 32'h0, 6'd0));
    push_word(op_word(FN_WRITE, 32'hFFFF_FFFF, 6'd63));
    push_word(op_word(FN_NOISE_LO, 32'h1234_5678, 6'd1));
    push_word(op_word(FN_NOISE_HI, 32'hFFFF_FFFF, 6'd63));
    // Small list: insert paths, cursor walk to both ends
    push_word(op_word(FN_INS_BEFORE, 32'h8000_0000, 6'd0));
    push_word(op_word(FN_INS_AFTER, 32'h7FFF_FFFF, 6'd0));
    push_word(op_word(FN_INS_BEFORE, 32'hFFFF_FFFF, 6'd0));
    push_word(op_word(FN_PREV, 32'h0, 6'd0));
    push_word(op_word(FN_PREV, 32'h0, 6'd0));
    push_word(op_word(FN_PREV, 32'h0, 6'd0));
    push_word(op_word(FN_NEXT, 32'h0, 6'd0));
    push_word(op_word(FN_NEXT, 32'h0, 6'd0));
    push_word(op_word(FN_NEXT, 32'h0, 6'd0));
    push_word(op_word(FN_READ, 32'h0, 6'd2));
    push_word(op_word(FN_READ, 32'h0, 6'd63));
    push_word(op_word(FN_WRITE, 32'h0, 6'd1));
    push_word(op_word(FN_START, 32'h0, 6'd0));
    push_word(op_word(FN_DELETE, 32'h0, 6'd0));
    push_word(op_word(FN_END, 32'h0, 6'd0));
    push_word(op_word(FN_DELETE, 32'h0, 6'd0));
    push_word(op_word(FN_DELETE, 32'h0, 6'd0));
    drain_results();

    // Fill to capacity, then hit the full case from both insert codes
    for (k = 0; k < 64; k++)
      push_word(op_word(k[0] ? FN_INS_AFTER : FN_INS_BEFORE, $urandom(), 6'd0));
    push_word(op_word(FN_INS_BEFORE, $urandom(), 6'd0));
    push_word(op_word(FN_INS_AFTER, $urandom(), 6'd0));
    push_word(op_word(FN_READ, 32'h0, 6'd63));
    push_word(op_word(FN_WRITE, 32'h5555_AAAA, 6'd63));
    push_word(op_word(FN_END, 32'h0, 6'd0));
    push_word(op_word(FN_DELETE, 32'h0, 6'd0));
    drain_results();

    // Random segments with varying mix and sender idling; the tail runs flat out
    total = 0;
    while (total < RAND_ITEMS) begin
      seg_len = $urandom_range(20, 80);
      mix = op_mix_t'($urandom_range(0, 2));
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      for (k = 0; k < seg_len && total < RAND_ITEMS; k++) begin
        if (total == RAND_ITEMS - CALM_ITEMS) calm <= 1'b1;
        if (total < RAND_ITEMS - CALM_ITEMS) begin
          if ($urandom_range(0, 99) < gap_pct) idle_sender();
          else if ($urandom_range(0, 59) == 0) drain_results();
        end
        w = rand_word(mix, list_len);
        push_word(w);
        if (w.func <= FN_WRITE) total++;
      end
    end

    // Wait for the last results, then watch for strays
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
